// ===== rtl/b64u_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package b64u_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned CharW  = 7;
    localparam int unsigned GroupW = 3 * ByteW;
    localparam int unsigned SextW  = 6;

    // Request handed from the byte packer to the character emitter
    typedef struct packed {
        logic              valid;
        logic [GroupW-1:0] grp;
        logic [1:0]        last_idx;   // index of the final character of this request
        logic              msg_end;    // final character closes the message
    } t_grp_req;

    // Map one 6-bit value to its base64url ASCII code
    function automatic logic [CharW-1:0] sext_to_char(input logic [SextW-1:0] v);
        logic [CharW-1:0] c;
        c = 7'(v);
        if (v < 6'd26) begin
            sext_to_char = c + 7'd65;
        end else if (v < 6'd52) begin
            sext_to_char = c + 7'd71;
        end else if (v < 6'd62) begin
            sext_to_char = c - 7'd4;
        end else if (v == 6'd62) begin
            sext_to_char = 7'd45;
        end else begin
            sext_to_char = 7'd95;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/b64u_pack.sv =====
`timescale 1ns / 1ps
`default_nettype none

module b64u_pack (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic [b64u_pkg::ByteW-1:0]    i_data_byte,
    input  wire logic                          i_final_byte,
    input  wire logic                          i_emit_free,
    output logic                               o_stall,
    output b64u_pkg::t_grp_req                 o_req
);

    logic [2*b64u_pkg::ByteW-1:0] r_pend, n_pend;
    logic [1:0]                   r_cnt, n_cnt;
    logic [1:0]                   cnt_eff;
    logic [b64u_pkg::ByteW-1:0]   b0, b1, b2;
    logic                         full;
    logic                         emit;
    logic                         accept;

    always_comb begin
        // a count of three is never reached; treat it as two held bytes
        cnt_eff = r_cnt[1] ? 2'd2 : r_cnt;
        b0 = '0;
        b1 = '0;
        b2 = '0;
        case (cnt_eff)
            2'd0: begin
                b0 = i_data_byte;
            end
            2'd1: begin
                b0 = r_pend[15:8];
                b1 = i_data_byte;
            end
            default: begin
                b0 = r_pend[15:8];
                b1 = r_pend[7:0];
                b2 = i_data_byte;
            end
        endcase
        full    = (cnt_eff == 2'd2);
        emit    = full || i_final_byte;
        o_stall = emit && !i_emit_free;
        accept  = i_valid && !o_stall;

        o_req.valid    = accept && emit;
        o_req.grp      = {b0, b1, b2};
        o_req.last_idx = full ? 2'd3 : cnt_eff + 2'd1;
        o_req.msg_end  = i_final_byte;

        n_pend = r_pend;
        n_cnt  = r_cnt;
        if (accept) begin
            if (emit) begin
                n_pend = '0;
                n_cnt  = '0;
            end else begin
                n_pend = {b0, b1};
                n_cnt  = cnt_eff + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_cnt  <= '0;
        end else begin
            r_pend <= n_pend;
            r_cnt  <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/b64u_emit.sv =====
`timescale 1ns / 1ps
`default_nettype none

module b64u_emit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire b64u_pkg::t_grp_req            i_req,
    output logic                               o_free,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [b64u_pkg::CharW-1:0]         o_out_char,
    output logic                               o_out_last
);

    logic                          r_valid, n_valid;
    logic [b64u_pkg::GroupW-1:0]   r_grp, n_grp;
    logic [1:0]                    r_idx, n_idx;
    logic [1:0]                    r_last_idx, n_last_idx;
    logic                          r_msg_end, n_msg_end;
    logic [b64u_pkg::SextW-1:0]    sext;
    logic                          pop;
    logic                          done;

    always_comb begin
        case (r_idx)
            2'd0:    sext = r_grp[23:18];
            2'd1:    sext = r_grp[17:12];
            2'd2:    sext = r_grp[11:6];
            default: sext = r_grp[5:0];
        endcase
        o_valid    = r_valid;
        o_out_char = b64u_pkg::sext_to_char(sext);
        o_out_last = r_msg_end && (r_idx == r_last_idx);

        pop    = r_valid && !i_stall;
        done   = pop && (r_idx == r_last_idx);
        o_free = !r_valid || done;

        n_valid    = r_valid;
        n_grp      = r_grp;
        n_idx      = r_idx;
        n_last_idx = r_last_idx;
        n_msg_end  = r_msg_end;
        if (i_req.valid) begin
            // load the next group as the current one drains
            n_valid    = 1'b1;
            n_grp      = i_req.grp;
            n_idx      = '0;
            n_last_idx = i_req.last_idx;
            n_msg_end  = i_req.msg_end;
        end else if (done) begin
            n_valid = 1'b0;
        end else if (pop) begin
            n_idx = r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp      <= n_grp;
        r_idx      <= n_idx;
        r_last_idx <= n_last_idx;
        r_msg_end  <= n_msg_end;
    end

endmodule

`default_nettype wire

// ===== rtl/base64url_stream_encoder_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_stall    i_data_byte[7:0], i_final_byte
// output    out        o_out_valid / i_out_stall  o_out_char[6:0], o_out_last
//
// A byte that only joins the open group is accepted without a stall, even while
// characters drain. A byte that closes a group (or a message) loads the
// character register and yields 2 to 4 characters at one per cycle while the
// output does not stall, so a full group of three bytes yields four characters.
// Reset is synchronous and clears the held bytes and the output valid flag.
// Output stalls hold the current character; input stalls only while a group
// waits for the character register to drain.

module base64url_stream_encoder_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [b64u_pkg::ByteW-1:0]    i_data_byte,
    input  wire logic                          i_final_byte,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [b64u_pkg::CharW-1:0]         o_out_char,
    output logic                               o_out_last
);

    b64u_pkg::t_grp_req grp_req;
    logic               emit_free;

    b64u_pack u_pack (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .i_emit_free  (emit_free),
        .o_stall      (o_in_stall),
        .o_req        (grp_req)
    );

    b64u_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (grp_req),
        .o_free     (emit_free),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_out_char (o_out_char),
        .o_out_last (o_out_last)
    );

endmodule

`default_nettype wire

// ===== rtl/b64u_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module b64u_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic                          o_in_stall,
    input  wire logic [b64u_pkg::ByteW-1:0]    i_data_byte,
    input  wire logic                          i_final_byte,
    input  wire logic                          o_out_valid,
    input  wire logic                          i_out_stall,
    input  wire logic [b64u_pkg::CharW-1:0]    o_out_char,
    input  wire logic                          o_out_last
);

    // a stalled character request holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_char)
            && $stable(o_out_last))
        else $error("stalled output request changed");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // a message end always produces characters next cycle
    a_final_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_final_byte |=> o_out_valid)
        else $error("final byte produced no characters");

    // input back-pressure only comes from characters still draining
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with idle output");

endmodule

bind base64url_stream_encoder_top b64u_checker u_b64u_checker (.*);

`default_nettype wire
